>>> design/ndb_pkg.sv
// Shared types, codes and constants for the neighbor discovery backoff block.
package ndb_pkg;

   localparam int PERIOD_W    = 12;
   localparam int MAC_W       = 48;
   localparam int IP_W        = 32;
   localparam int RND_W       = 16;
   localparam int REQ_W       = 3;
   localparam int COUNT_OUT_W = 7;
   localparam int SUM_W       = PERIOD_W + 1;
   localparam int DIV_CNT_W   = $clog2(RND_W + 1);

   localparam logic [SUM_W-1:0]    PERIOD_CAP = SUM_W'(3600);
   localparam logic [SUM_W-1:0]    MIN_DELAY  = SUM_W'(2);
   localparam logic [PERIOD_W-1:0] DELAY_MAX  = '1;

   typedef enum logic [REQ_W-1:0] {
      REQ_START   = 3'd0,
      REQ_TIMER   = 3'd1,
      REQ_ANNOUNC = 3'd2,
      REQ_DISABLE = 3'd3,
      REQ_ENABLE  = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORK,
      ST_COMMIT
   } ndb_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic run;
      logic commit;
   } ndb_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic div_done;
      logic out_free;
   } ndb_sts_type;

   function automatic logic [PERIOD_W-1:0] sat_delay(input logic [SUM_W-1:0] d);
      logic [PERIOD_W-1:0] r;
      r = (d > {1'b0, DELAY_MAX}) ? DELAY_MAX : d[PERIOD_W-1:0];
      return r;
   endfunction

endpackage

>>> design/ndb_if.sv
// Channel interfaces: event requests, results and the period register write.
interface ndb_req_if import ndb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [MAC_W-1:0]    neighbor_mac;
   logic [IP_W-1:0]     neighbor_ip;
   logic [RND_W-1:0]    random_value;

   modport source (output valid, req_type, neighbor_mac, neighbor_ip, random_value,
                   input ready);
   modport sink   (input valid, req_type, neighbor_mac, neighbor_ip, random_value,
                   output ready);
endinterface

interface ndb_rsp_if import ndb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   send_announce;
   logic                   cancel_timer;
   logic                   arm_timer;
   logic [PERIOD_W-1:0]    timer_delay;
   logic                   new_neighbor;
   logic [IP_W-1:0]        new_neighbor_ip;
   logic                   shutdown_request;
   logic [COUNT_OUT_W-1:0] neighbor_count;
   logic                   table_full;

   modport source (output valid, send_announce, cancel_timer, arm_timer, timer_delay,
                   new_neighbor, new_neighbor_ip, shutdown_request, neighbor_count,
                   table_full,
                   input ready);
   modport sink   (input valid, send_announce, cancel_timer, arm_timer, timer_delay,
                   new_neighbor, new_neighbor_ip, shutdown_request, neighbor_count,
                   table_full,
                   output ready);
endinterface

interface ndb_csr_if import ndb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] announce_period;

   modport source (output valid, announce_period, input ready);
   modport sink   (input valid, announce_period, output ready);
endinterface

>>> design/ndb_ctrl.sv
// Sequencing state machine: accept, scan and divide, commit the result beat.
module ndb_ctrl import ndb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ndb_sts_type sts,
   output ndb_cmd_type cmd
);

   ndb_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_WORK;
         end
         ST_WORK: begin
            if (sts.scan_done && sts.div_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.run    = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_WORK:   cmd.run    = 1'b1;
         ST_COMMIT: cmd.commit = sts.out_free;
         default: ;
      endcase
   end

   a_commit_after_work: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(state_ff) == ST_WORK || $past(state_ff) == ST_COMMIT)
      else $error("commit without finished work");

   a_done_before_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WORK && state_in == ST_COMMIT) |-> sts.scan_done && sts.div_done)
      else $error("left work before scan and divide finished");

   a_load_starts_work: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_WORK)
      else $error("accepted beat did not start work");

endmodule

>>> design/ndb_dp.sv
// Datapath: event latch, MAC table scan, remainder unit, state and result register.
module ndb_dp import ndb_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  ndb_cmd_type      cmd,
   output ndb_sts_type      sts,
   input  logic [REQ_W-1:0] req_type,
   input  logic [MAC_W-1:0] neighbor_mac,
   input  logic [IP_W-1:0]  neighbor_ip,
   input  logic [RND_W-1:0] random_value,
   ndb_csr_if.sink          csr,
   ndb_rsp_if.source        rsp
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // latched event
   logic [REQ_W-1:0] type_ff;
   logic [MAC_W-1:0] mac_ff;
   logic [IP_W-1:0]  ip_ff;
   logic [RND_W-1:0] rnd_ff;

   // block state
   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] cur_ff, cur_in;
   logic                en_ff, en_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // table and scan
   logic [MAC_W-1:0]  mac_mem [TABLE_DEPTH];
   logic [MAC_W-1:0]  rd_data_ff;
   logic              rd_valid_ff;
   logic [CNT_W-1:0]  scan_idx_ff;
   logic              known_ff;
   logic              table_wr;

   // remainder unit
   logic [PERIOD_W-1:0]  rem_ff;
   logic [RND_W-1:0]     dvd_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [SUM_W-1:0]     rem_shift;
   logic [PERIOD_W-1:0]  rem_next;

   // result register
   logic                   rsp_valid_ff;
   logic                   send_ff, send_in;
   logic                   cancel_ff, cancel_in;
   logic                   arm_ff, arm_in;
   logic [PERIOD_W-1:0]    delay_ff, delay_in;
   logic                   fresh_ff, fresh_in;
   logic [IP_W-1:0]        fresh_ip_ff, fresh_ip_in;
   logic                   shut_ff, shut_in;
   logic                   full_ff, full_in;

   logic [PERIOD_W-1:0] rnd_mod;
   logic [PERIOD_W-1:0] restart_delay;
   logic [SUM_W-1:0]    dbl;
   logic [PERIOD_W-1:0] backoff_period;
   logic [PERIOD_W-1:0] backoff_delay;
   logic                has_room;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_W'(10);
      end else if (csr.valid) begin
         period_ff <= csr.announce_period;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         mac_ff  <= neighbor_mac;
         ip_ff   <= neighbor_ip;
         rnd_ff  <= random_value;
      end
   end

   // Linear scan: one entry per cycle through the registered read port.
   always_ff @(posedge clock) begin
      if (table_wr) begin
         mac_mem[count_ff[ADDR_W-1:0]] <= mac_ff;
      end
      rd_data_ff <= mac_mem[scan_idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         rd_valid_ff <= 1'b0;
         known_ff    <= 1'b0;
      end else if (cmd.load) begin
         scan_idx_ff <= '0;
         rd_valid_ff <= 1'b0;
         known_ff    <= 1'b0;
      end else if (cmd.run) begin
         rd_valid_ff <= (scan_idx_ff < count_ff);
         if (scan_idx_ff < count_ff) scan_idx_ff <= scan_idx_ff + 1'b1;
         if (rd_valid_ff && rd_data_ff == mac_ff) known_ff <= 1'b1;
      end
   end

   // Restoring remainder, one dividend bit per cycle.
   assign rem_shift = {rem_ff, dvd_ff[RND_W-1]};
   assign rem_next  = (rem_shift >= {1'b0, period_ff}) ?
                      PERIOD_W'(rem_shift - {1'b0, period_ff}) : rem_shift[PERIOD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.load) begin
         div_cnt_ff <= '0;
      end else if (cmd.run && !sts.div_done) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff <= '0;
         dvd_ff <= random_value;
      end else if (cmd.run && !sts.div_done) begin
         rem_ff <= rem_next;
         dvd_ff <= {dvd_ff[RND_W-2:0], 1'b0};
      end
   end

   assign sts.scan_done = (scan_idx_ff == count_ff) && !rd_valid_ff;
   assign sts.div_done  = (div_cnt_ff == DIV_CNT_W'(RND_W));
   assign sts.out_free  = !rsp_valid_ff || rsp.ready;

   // result of the event
   assign rnd_mod        = (period_ff == '0) ? '0 : rem_ff;
   assign restart_delay  = sat_delay({1'b0, rnd_mod} + MIN_DELAY);
   assign dbl            = {cur_ff, 1'b0};
   assign backoff_period = (dbl < PERIOD_CAP) ? dbl[PERIOD_W-1:0] : cur_ff;
   assign backoff_delay  = sat_delay({1'b0, backoff_period} + SUM_W'(rnd_ff[0]));
   assign has_room       = (count_ff < CNT_W'(TABLE_DEPTH));

   always_comb begin
      send_in     = 1'b0;
      cancel_in   = 1'b0;
      arm_in      = 1'b0;
      delay_in    = '0;
      fresh_in    = 1'b0;
      fresh_ip_in = '0;
      shut_in     = 1'b0;
      full_in     = 1'b0;
      cur_in      = cur_ff;
      en_in       = en_ff;
      count_in    = count_ff;
      table_wr    = 1'b0;
      case (type_ff)
         REQ_START: begin
            send_in  = 1'b1;
            cur_in   = period_ff;
            arm_in   = 1'b1;
            delay_in = period_ff;
         end
         REQ_TIMER: begin
            if (en_ff) begin
               send_in  = 1'b1;
               cur_in   = backoff_period;
               arm_in   = 1'b1;
               delay_in = backoff_delay;
            end
         end
         REQ_ANNOUNC: begin
            if (!known_ff) begin
               if (has_room) begin
                  table_wr    = cmd.commit;
                  count_in    = count_ff + 1'b1;
                  fresh_in    = 1'b1;
                  fresh_ip_in = ip_ff;
                  if (en_ff) begin
                     cancel_in = 1'b1;
                     cur_in    = period_ff;
                     arm_in    = 1'b1;
                     delay_in  = restart_delay;
                  end
               end else begin
                  full_in = 1'b1;
               end
            end
         end
         REQ_DISABLE: begin
            if (en_ff) begin
               en_in     = 1'b0;
               cancel_in = 1'b1;
               shut_in   = 1'b1;
            end
         end
         REQ_ENABLE: begin
            if (!en_ff) begin
               en_in    = 1'b1;
               cur_in   = period_ff;
               arm_in   = 1'b1;
               delay_in = restart_delay;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         en_ff        <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            cur_ff   <= cur_in;
            en_ff    <= en_in;
            count_ff <= count_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         send_ff     <= send_in;
         cancel_ff   <= cancel_in;
         arm_ff      <= arm_in;
         delay_ff    <= delay_in;
         fresh_ff    <= fresh_in;
         fresh_ip_ff <= fresh_ip_in;
         shut_ff     <= shut_in;
         full_ff     <= full_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.send_announce    = send_ff;
   assign rsp.cancel_timer     = cancel_ff;
   assign rsp.arm_timer        = arm_ff;
   assign rsp.timer_delay      = delay_ff;
   assign rsp.new_neighbor     = fresh_ff;
   assign rsp.new_neighbor_ip  = fresh_ip_ff;
   assign rsp.shutdown_request = shut_ff;
   assign rsp.neighbor_count   = COUNT_OUT_W'(count_ff);
   assign rsp.table_full       = full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("neighbor count beyond table depth");

   a_store_counts: assert property (@(posedge clock) disable iff (reset)
      table_wr |=> count_ff == $past(count_ff) + 1'b1 && rsp.new_neighbor)
      else $error("table write without count step and report");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_valid_ff || rsp.ready)
      else $error("result register overwritten while held");

endmodule

>>> design/neighbor_discovery_backoff_core.sv
// Neighbor discovery backoff core: top level joining controller and datapath.
// One event beat is handled at a time. After a beat is taken the core scans the
// stored MAC entries one per cycle through the table's registered read port
// while a 16-step restoring remainder unit forms random_value mod
// announce_period; the result beat is registered once both have finished and
// the result register is free. At most TABLE_DEPTH neighbors are stored.
// The next event beat is taken the cycle after the result is registered, even
// while that result still waits. The MAC table needs no clearing after reset:
// only entries below the count are read. announce_period may be written only
// while the core is idle.
module neighbor_discovery_backoff_core import ndb_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   ndb_req_if.sink    req_chan,
   ndb_rsp_if.source  rsp_chan,
   ndb_csr_if.sink    csr_chan
);

   ndb_cmd_type cmd;
   ndb_sts_type sts;
   logic        req_ready;

   assign req_chan.ready = req_ready;

   ndb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ndb_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_type     (req_chan.req_type),
      .neighbor_mac (req_chan.neighbor_mac),
      .neighbor_ip  (req_chan.neighbor_ip),
      .random_value (req_chan.random_value),
      .csr          (csr_chan),
      .rsp          (rsp_chan)
   );

endmodule
